// ===== rtl/kfpv_pkg.sv =====
// kfpv_pkg: shared types, constants and the 32-bit saturation helper
// for the constant-velocity kalman filter; no dependencies
`timescale 1ns / 1ps

package kfpv_pkg;

    localparam int DEF_FRAC_BITS = 16;
    localparam int DATA_W        = 32;
    localparam int CFG_IDX_W     = 3;
    localparam int SAT_W         = 66;
    localparam int VAR_UNITS     = 1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MEAS_NOISE = 3'd0,
        CFG_DRIFT_POS  = 3'd1,
        CFG_DRIFT_VEL  = 3'd2,
        CFG_INIT_POS   = 3'd3,
        CFG_INIT_VEL   = 3'd4,
        CFG_INIT_VAR   = 3'd5
    } kfpv_cfg_idx_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic prep;
        logic div_step;
        logic gain;
        logic mul_step;
        logic pred;
    } kfpv_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic mul_done;
    } kfpv_sts_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic                     clip;
    } kfpv_sat_t;

    function automatic kfpv_sat_t sat32(input logic signed [SAT_W-1:0] v);
        kfpv_sat_t r;
        if ((&v[SAT_W-1:DATA_W-1]) || !(|v[SAT_W-1:DATA_W-1])) begin
            r.val  = v[DATA_W-1:0];
            r.clip = 1'b0;
        end else begin
            r.val  = v[SAT_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
            r.clip = 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== rtl/kalman_filter_pos_vel_1d_core.sv =====
// kalman_filter_pos_vel_1d_core: top level of the two-state kalman filter
// depends on kfpv_pkg, kfpv_ctrl and kfpv_dp
//
//   channel   dir  handshake            payload
//   -------   ---  ---------            -------
//   cfg       in   cfg_wr_en            cfg_wr_index, cfg_wr_data
//   s_        in   s_valid / s_ready    s_meas, s_restart
//   m_        out  m_valid / m_ready    m_est_pos .. m_cov_vv, m_saturated
//
// the result of a transaction is produced by the bit-per-cycle gain divider
// and then the six products through the single shared multiplier, and is
// registered in the prediction step; the next transaction can be accepted
// in the same cycle that the result becomes valid, not while one is in flight
// s_ready is high only while no transaction is in progress
// the result sits in an output register; a stalled m_ready holds only the
// final state-update cycle of the next transaction
// aresetn is synchronous, active low; it restores the register defaults
// and the state to zero position, zero velocity and 1000.0 variance
`timescale 1ns / 1ps

module kalman_filter_pos_vel_1d_core #(
    parameter int FRAC_BITS = kfpv_pkg::DEF_FRAC_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration writes
    input  logic                                 cfg_wr_en,
    input  logic [kfpv_pkg::CFG_IDX_W-1:0]       cfg_wr_index,
    input  logic [kfpv_pkg::DATA_W-1:0]          cfg_wr_data,
    // measurement input
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [kfpv_pkg::DATA_W-1:0]   s_meas,
    input  logic                                 s_restart,
    // estimate output
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [kfpv_pkg::DATA_W-1:0]   m_est_pos,
    output logic signed [kfpv_pkg::DATA_W-1:0]   m_est_vel,
    output logic signed [kfpv_pkg::DATA_W-1:0]   m_cov_pp,
    output logic signed [kfpv_pkg::DATA_W-1:0]   m_cov_pv,
    output logic signed [kfpv_pkg::DATA_W-1:0]   m_cov_vp,
    output logic signed [kfpv_pkg::DATA_W-1:0]   m_cov_vv,
    output logic                                 m_saturated
);

    kfpv_pkg::kfpv_cmd_t cmd;
    kfpv_pkg::kfpv_sts_t sts;

    // sequencer: idle, restart/residual prep, divide, gain fix,
    // multiply-accumulate, predict and publish
    kfpv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // arithmetic, filter state and config registers
    kfpv_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_meas       (s_meas),
        .s_restart    (s_restart),
        .est_pos      (m_est_pos),
        .est_vel      (m_est_vel),
        .cov_pp       (m_cov_pp),
        .cov_pv       (m_cov_pv),
        .cov_vp       (m_cov_vp),
        .cov_vv       (m_cov_vv),
        .saturated    (m_saturated)
    );

    // only one transaction in flight at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a transaction was in progress");

    // a new result only appears at the end of a step
    a_result_from_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.pred))
        else $error("result raised without a prediction step");

    // the prediction never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pred |-> (!m_valid || m_ready))
        else $error("pending result overwritten");

    // reset leaves no result pending
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

// ===== rtl/kfpv_ctrl.sv =====
// kfpv_ctrl: sequencing state machine of the filter step
// depends on kfpv_pkg for command and status structs
`timescale 1ns / 1ps

module kfpv_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  kfpv_pkg::kfpv_sts_t  sts,
    output kfpv_pkg::kfpv_cmd_t  cmd
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_PREP = 6'b000010,
        ST_DIV  = 6'b000100,
        ST_GAIN = 6'b001000,
        ST_MUL  = 6'b010000,
        ST_PRED = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                cmd.capture = s_valid;
                if (s_valid) state_next = ST_PREP;
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_done) state_next = ST_GAIN;
            end
            ST_GAIN: begin
                cmd.gain   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1;
                if (sts.mul_done) state_next = ST_PRED;
            end
            ST_PRED: begin
                // hold until the result slot is free
                if (out_free) begin
                    cmd.pred     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== rtl/kfpv_dp.sv =====
// kfpv_dp: config registers, filter state, dual restoring divider,
// shared multiplier with rounding accumulate; depends on kfpv_pkg
`timescale 1ns / 1ps

module kfpv_dp #(
    parameter int FRAC_BITS = kfpv_pkg::DEF_FRAC_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  kfpv_pkg::kfpv_cmd_t                  cmd,
    output kfpv_pkg::kfpv_sts_t                  sts,
    input  logic                                 cfg_wr_en,
    input  logic [kfpv_pkg::CFG_IDX_W-1:0]       cfg_wr_index,
    input  logic [kfpv_pkg::DATA_W-1:0]          cfg_wr_data,
    input  logic signed [kfpv_pkg::DATA_W-1:0]   s_meas,
    input  logic                                 s_restart,
    output logic signed [kfpv_pkg::DATA_W-1:0]   est_pos,
    output logic signed [kfpv_pkg::DATA_W-1:0]   est_vel,
    output logic signed [kfpv_pkg::DATA_W-1:0]   cov_pp,
    output logic signed [kfpv_pkg::DATA_W-1:0]   cov_pv,
    output logic signed [kfpv_pkg::DATA_W-1:0]   cov_vp,
    output logic signed [kfpv_pkg::DATA_W-1:0]   cov_vv,
    output logic                                 saturated
);

    localparam int DW     = kfpv_pkg::DATA_W;
    localparam int SW     = kfpv_pkg::SAT_W;
    localparam int DIV_W  = DW + FRAC_BITS;
    localparam int CNT_W  = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);
    localparam logic [DW-1:0] RST_ONE = DW'(64'd1 << FRAC_BITS);
    localparam logic [DW-1:0] RST_VAR = DW'(64'(kfpv_pkg::VAR_UNITS) << FRAC_BITS);
    localparam logic signed [2*DW-1:0] ROUND_HALF = (2*DW)'(64'd1 << (FRAC_BITS - 1));

    typedef enum logic [2:0] {
        OP_NX0 = 3'd0,
        OP_NX1 = 3'd1,
        OP_N00 = 3'd2,
        OP_N01 = 3'd3,
        OP_N10 = 3'd4,
        OP_N11 = 3'd5
    } mul_op_t;

    // configuration
    logic [DW-2:0]        meas_noise_reg;
    logic signed [DW-1:0] drift_pos_reg, drift_vel_reg, init_pos_reg, init_vel_reg;
    logic [DW-1:0]        init_var_reg;

    // filter state and working registers
    logic signed [DW-1:0] x0_reg, x1_reg, p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [DW-1:0] meas_reg, y_reg, k0_reg, k1_reg;
    logic                 restart_reg;
    logic signed [DW-1:0] nx0_reg, nx1_reg, n00_reg, n01_reg, n10_reg, n11_reg;
    logic                 clip_reg;

    // divider
    logic [DW:0]          dvs_reg;
    logic [DW+1:0]        rem0_reg, rem1_reg;
    logic [DIV_W-1:0]     quo0_reg, quo1_reg;
    logic                 neg0_reg, neg1_reg, s_zero_reg;
    logic [CNT_W-1:0]     cnt_reg;

    // multiplier
    logic [2:0]             mul_idx_reg, prod_idx_reg;
    logic                   prod_vld_reg;
    logic signed [2*DW-1:0] prod_reg;

    // output registers
    logic signed [DW-1:0] est_pos_reg, est_vel_reg, cov_pp_reg, cov_pv_reg;
    logic signed [DW-1:0] cov_vp_reg, cov_vv_reg;
    logic                 saturated_reg;

    // ---------------- configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            meas_noise_reg <= RST_ONE[DW-2:0];
            drift_pos_reg  <= '0;
            drift_vel_reg  <= '0;
            init_pos_reg   <= '0;
            init_vel_reg   <= '0;
            init_var_reg   <= RST_VAR;
        end else if (cfg_wr_en) begin
            case (kfpv_pkg::kfpv_cfg_idx_t'(cfg_wr_index))
                kfpv_pkg::CFG_MEAS_NOISE: meas_noise_reg <= cfg_wr_data[DW-2:0];
                kfpv_pkg::CFG_DRIFT_POS:  drift_pos_reg  <= cfg_wr_data;
                kfpv_pkg::CFG_DRIFT_VEL:  drift_vel_reg  <= cfg_wr_data;
                kfpv_pkg::CFG_INIT_POS:   init_pos_reg   <= cfg_wr_data;
                kfpv_pkg::CFG_INIT_VEL:   init_vel_reg   <= cfg_wr_data;
                kfpv_pkg::CFG_INIT_VAR:   init_var_reg   <= {1'b0, cfg_wr_data[DW-2:0]};
                default: ;
            endcase
        end
    end

    // ---------------- prep: restart mux, residual, innovation variance
    logic signed [DW-1:0] x0_eff, x1_eff, p00_eff, p01_eff, p10_eff, p11_eff;
    logic signed [DW:0]   s_val;
    logic [DW:0]          s_mag;
    logic [DW-1:0]        p00_mag, p10_mag;
    kfpv_pkg::kfpv_sat_t  y_sat;

    always_comb begin
        x0_eff  = restart_reg ? init_pos_reg : x0_reg;
        x1_eff  = restart_reg ? init_vel_reg : x1_reg;
        p00_eff = restart_reg ? init_var_reg : p00_reg;
        p01_eff = restart_reg ? '0 : p01_reg;
        p10_eff = restart_reg ? '0 : p10_reg;
        p11_eff = restart_reg ? init_var_reg : p11_reg;
        y_sat   = kfpv_pkg::sat32(SW'(meas_reg) - SW'(x0_eff));
        s_val   = (DW+1)'(p00_eff) + signed'({2'b00, meas_noise_reg});
        s_mag   = s_val[DW] ? unsigned'(-s_val) : unsigned'(s_val);
        p00_mag = p00_eff[DW-1] ? DW'(-p00_eff) : DW'(p00_eff);
        p10_mag = p10_eff[DW-1] ? DW'(-p10_eff) : DW'(p10_eff);
    end

    // ---------------- one quotient bit per cycle for both gains
    logic [DW+1:0] rem0_sh, rem1_sh;
    logic          ge0, ge1;

    assign rem0_sh = {rem0_reg[DW:0], quo0_reg[DIV_W-1]};
    assign rem1_sh = {rem1_reg[DW:0], quo1_reg[DIV_W-1]};
    assign ge0     = rem0_sh >= {1'b0, dvs_reg};
    assign ge1     = rem1_sh >= {1'b0, dvs_reg};

    function automatic kfpv_pkg::kfpv_sat_t fix_gain(input logic [DIV_W-1:0] q,
                                                     input logic neg, input logic zero);
        kfpv_pkg::kfpv_sat_t r;
        logic signed [DIV_W:0] sq;
        sq = neg ? -signed'({1'b0, q}) : signed'({1'b0, q});
        r  = kfpv_pkg::sat32(SW'(sq));
        if (zero) begin
            r.val  = '0;
            r.clip = 1'b0;
        end
        return r;
    endfunction

    kfpv_pkg::kfpv_sat_t k0_sat, k1_sat;
    assign k0_sat = fix_gain(quo0_reg, neg0_reg, s_zero_reg);
    assign k1_sat = fix_gain(quo1_reg, neg1_reg, s_zero_reg);

    // ---------------- shared multiplier, rounding and correction
    logic signed [DW-1:0]   mul_a, mul_b, acc_base;
    logic signed [2*DW-1:0] prod_rnd;
    logic                   acc_sub, mul_issue;
    kfpv_pkg::kfpv_sat_t    acc_sat;

    assign mul_issue = cmd.mul_step && (mul_idx_reg <= OP_N11);

    always_comb begin
        case (mul_op_t'(mul_idx_reg))
            OP_NX0:  begin mul_a = k0_reg; mul_b = y_reg;   end
            OP_NX1:  begin mul_a = k1_reg; mul_b = y_reg;   end
            OP_N00:  begin mul_a = k0_reg; mul_b = p00_reg; end
            OP_N01:  begin mul_a = k0_reg; mul_b = p01_reg; end
            OP_N10:  begin mul_a = k1_reg; mul_b = p00_reg; end
            OP_N11:  begin mul_a = k1_reg; mul_b = p01_reg; end
            default: begin mul_a = '0;     mul_b = '0;      end
        endcase
    end

    always_comb begin
        acc_sub = 1'b1;
        case (mul_op_t'(prod_idx_reg))
            OP_NX0:  begin acc_base = x0_reg; acc_sub = 1'b0; end
            OP_NX1:  begin acc_base = x1_reg; acc_sub = 1'b0; end
            OP_N00:  acc_base = p00_reg;
            OP_N01:  acc_base = p01_reg;
            OP_N10:  acc_base = p10_reg;
            OP_N11:  acc_base = p11_reg;
            default: acc_base = '0;
        endcase
        prod_rnd = (prod_reg + ROUND_HALF) >>> FRAC_BITS;
        acc_sat  = kfpv_pkg::sat32(acc_sub ? SW'(acc_base) - SW'(prod_rnd)
                                           : SW'(acc_base) + SW'(prod_rnd));
    end

    assign sts.div_done = cmd.div_step && (cnt_reg == CNT_LAST);
    assign sts.mul_done = prod_vld_reg && (prod_idx_reg == OP_N11);

    // ---------------- prediction
    kfpv_pkg::kfpv_sat_t pr_pos, pr_vel, pr_pp, pr_pv, pr_vp;
    always_comb begin
        pr_pos = kfpv_pkg::sat32(SW'(nx0_reg) + SW'(nx1_reg) + SW'(drift_pos_reg));
        pr_vel = kfpv_pkg::sat32(SW'(nx1_reg) + SW'(drift_vel_reg));
        pr_pp  = kfpv_pkg::sat32(SW'(n00_reg) + SW'(n01_reg) + SW'(n10_reg) + SW'(n11_reg));
        pr_pv  = kfpv_pkg::sat32(SW'(n01_reg) + SW'(n11_reg));
        pr_vp  = kfpv_pkg::sat32(SW'(n10_reg) + SW'(n11_reg));
    end

    // ---------------- state and working registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x0_reg       <= '0;
            x1_reg       <= '0;
            p00_reg      <= RST_VAR;
            p01_reg      <= '0;
            p10_reg      <= '0;
            p11_reg      <= RST_VAR;
            cnt_reg      <= '0;
            mul_idx_reg  <= '0;
            prod_vld_reg <= 1'b0;
            clip_reg     <= 1'b0;
        end else begin
            if (cmd.capture) begin
                meas_reg    <= s_meas;
                restart_reg <= s_restart;
            end
            if (cmd.prep) begin
                x0_reg     <= x0_eff;
                x1_reg     <= x1_eff;
                p00_reg    <= p00_eff;
                p01_reg    <= p01_eff;
                p10_reg    <= p10_eff;
                p11_reg    <= p11_eff;
                y_reg      <= y_sat.val;
                clip_reg   <= y_sat.clip;
                dvs_reg    <= s_mag;
                s_zero_reg <= (s_val == '0);
                neg0_reg   <= p00_eff[DW-1] ^ s_val[DW];
                neg1_reg   <= p10_eff[DW-1] ^ s_val[DW];
                quo0_reg   <= {p00_mag, {FRAC_BITS{1'b0}}};
                quo1_reg   <= {p10_mag, {FRAC_BITS{1'b0}}};
                rem0_reg   <= '0;
                rem1_reg   <= '0;
                cnt_reg    <= '0;
            end
            if (cmd.div_step) begin
                rem0_reg <= ge0 ? rem0_sh - {1'b0, dvs_reg} : rem0_sh;
                rem1_reg <= ge1 ? rem1_sh - {1'b0, dvs_reg} : rem1_sh;
                quo0_reg <= {quo0_reg[DIV_W-2:0], ge0};
                quo1_reg <= {quo1_reg[DIV_W-2:0], ge1};
                cnt_reg  <= cnt_reg + 1'b1;
            end
            if (cmd.gain) begin
                k0_reg       <= k0_sat.val;
                k1_reg       <= k1_sat.val;
                clip_reg     <= clip_reg | k0_sat.clip | k1_sat.clip;
                mul_idx_reg  <= OP_NX0;
                prod_vld_reg <= 1'b0;
            end
            if (cmd.mul_step) begin
                prod_vld_reg <= mul_issue;
                if (mul_issue) begin
                    prod_reg     <= mul_a * mul_b;
                    prod_idx_reg <= mul_idx_reg;
                    mul_idx_reg  <= mul_idx_reg + 1'b1;
                end
                if (prod_vld_reg) begin
                    clip_reg <= clip_reg | acc_sat.clip;
                    case (mul_op_t'(prod_idx_reg))
                        OP_NX0:  nx0_reg <= acc_sat.val;
                        OP_NX1:  nx1_reg <= acc_sat.val;
                        OP_N00:  n00_reg <= acc_sat.val;
                        OP_N01:  n01_reg <= acc_sat.val;
                        OP_N10:  n10_reg <= acc_sat.val;
                        OP_N11:  n11_reg <= acc_sat.val;
                        default: ;
                    endcase
                end
            end
            if (cmd.pred) begin
                x0_reg  <= pr_pos.val;
                x1_reg  <= pr_vel.val;
                p00_reg <= pr_pp.val;
                p01_reg <= pr_pv.val;
                p10_reg <= pr_vp.val;
                p11_reg <= n11_reg;
            end
        end
    end

    // result registers, no reset needed
    always_ff @(posedge aclk) begin
        if (cmd.pred) begin
            est_pos_reg   <= pr_pos.val;
            est_vel_reg   <= pr_vel.val;
            cov_pp_reg    <= pr_pp.val;
            cov_pv_reg    <= pr_pv.val;
            cov_vp_reg    <= pr_vp.val;
            cov_vv_reg    <= n11_reg;
            saturated_reg <= clip_reg | pr_pos.clip | pr_vel.clip | pr_pp.clip
                             | pr_pv.clip | pr_vp.clip;
        end
    end

    assign est_pos   = est_pos_reg;
    assign est_vel   = est_vel_reg;
    assign cov_pp    = cov_pp_reg;
    assign cov_pv    = cov_pv_reg;
    assign cov_vp    = cov_vp_reg;
    assign cov_vv    = cov_vv_reg;
    assign saturated = saturated_reg;

endmodule
